FILE: sv/tmtp_pkg.sv
// Shared types and constants of the trapezoid move-time predictor.
package tmtp_pkg;

	localparam int WORD_W = 32;
	localparam int WIDE_W = 64;
	localparam int LIMIT_W = 31;

	// configuration register indexes
	localparam logic REG_ACCEL = 1'b0;
	localparam logic REG_VEL   = 1'b1;

	typedef struct packed {
		logic signed [WORD_W-1:0] joint_distance;
		logic signed [WORD_W-1:0] joint_velocity;
		logic                     last_joint;
	} tmtp_in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] plateau_start;
		logic signed [WORD_W-1:0] rampdown_start;
		logic signed [WORD_W-1:0] move_end;
	} tmtp_out_t;

endpackage

FILE: sv/tmtp_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
module tmtp_mul import tmtp_pkg::*; (
	input  logic              clk,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic [WIDE_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

FILE: sv/tmtp_csub.sv
// Shared 64-bit compare-subtract step for the divider and square root.
module tmtp_csub import tmtp_pkg::*; (
	input  logic [WIDE_W-1:0] a,
	input  logic [WIDE_W-1:0] b,
	output logic              ge,
	output logic [WIDE_W-1:0] diff
);

	assign ge   = (a >= b);
	assign diff = a - b;

endmodule

FILE: sv/tmtp_core.sv
// Sequencer and datapath: classify one joint, time its profile, keep the best.
module tmtp_core import tmtp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tmtp_in_t           item,
	input  logic [LIMIT_W-1:0] accel,
	input  logic [LIMIT_W-1:0] vel,
	input  logic               out_free,
	output logic               busy,
	output logic               emit,
	output tmtp_out_t          res
);

	localparam int NUM_W = 66 + FRAC_BITS;
	localparam int REARM_I = -10 * (2 ** FRAC_BITS);
	localparam int NEG1_I = -1 * (2 ** FRAC_BITS);
	localparam logic [WORD_W-1:0] REARM = WORD_W'(REARM_I);
	localparam logic [WORD_W-1:0] NEG_ONE = WORD_W'(NEG1_I);
	localparam logic [WORD_W-1:0] SAT = 32'h7FFF_FFFF;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_M1   = 5'd1;
	localparam logic [4:0] S_M2   = 5'd2;
	localparam logic [4:0] S_M3   = 5'd3;
	localparam logic [4:0] S_M4   = 5'd4;
	localparam logic [4:0] S_CLS  = 5'd5;
	localparam logic [4:0] S_CLS2 = 5'd6;
	localparam logic [4:0] S_SQ   = 5'd7;
	localparam logic [4:0] S_TRI  = 5'd8;
	localparam logic [4:0] S_TRI2 = 5'd9;
	localparam logic [4:0] S_PE   = 5'd10;
	localparam logic [4:0] S_PE2  = 5'd11;
	localparam logic [4:0] S_PE3  = 5'd12;
	localparam logic [4:0] S_PE4  = 5'd13;
	localparam logic [4:0] S_PE5  = 5'd14;
	localparam logic [4:0] S_PE6  = 5'd15;
	localparam logic [4:0] S_ADD  = 5'd16;
	localparam logic [4:0] S_DIV0 = 5'd17;
	localparam logic [4:0] S_DIVI = 5'd18;
	localparam logic [4:0] S_DIVW = 5'd19;
	localparam logic [4:0] S_UPD  = 5'd20;

	localparam logic [1:0] DST_DOWN = 2'd0;
	localparam logic [1:0] DST_PLAT = 2'd1;
	localparam logic [1:0] DST_TMP  = 2'd2;
	localparam logic [1:0] DST_END  = 2'd3;

	logic [4:0] state_q, ret_q;
	logic [1:0] dst_q;
	logic [4:0] cnt_q;
	logic last_q, decel_q, eneg_q;
	logic [WORD_W-1:0] l_q, au_q, t_q, ae_q;
	logic signed [32:0] u_q;
	logic [WIDE_W-1:0] two_la_q, uu_q, ww_q, aw2_q, sum_q, neg_q;
	logic [64:0] plo_q;
	logic [NUM_W-1:0] num_q;
	logic [WIDE_W-1:0] den_q, rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] plat_q, down_q, tmp_q, end_q;
	logic signed [WORD_W-1:0] best_plat_q, best_down_q, best_end_q;

	logic [WORD_W-1:0] a_eff, w_eff;
	logic [WORD_W-1:0] mul_a, mul_b;
	logic [WIDE_W-1:0] prod;
	logic [WIDE_W-1:0] cs_a, cs_b, cs_diff;
	logic cs_ge;
	logic [WIDE_W-1:0] hi64, div_a, sq_a, trial;
	logic [30:0] low31;
	logic signed [32:0] v_ext, u_c;
	logic signed [33:0] e_c, e_abs, tdiff;
	logic [65:0] n_c;
	logic [32:0] add_c;
	logic take;

	assign a_eff = (accel == '0) ? 32'd1 : {1'b0, accel};
	assign w_eff = (vel == '0) ? 32'd1 : {1'b0, vel};

	assign hi64  = WIDE_W'(num_q[NUM_W-1:31]);
	assign low31 = num_q[30:0];
	assign div_a = {rem_q[62:0], low31[cnt_q]};
	assign sq_a  = {rem_q[61:0], num_q[63:62]};
	assign trial = {30'd0, quo_q, 2'b01};

	// sign of the distance, zero counts as positive
	assign v_ext = {item.joint_velocity[31], item.joint_velocity};
	assign u_c   = item.joint_distance[31] ? -v_ext : v_ext;

	assign e_c   = $signed({2'b00, w_eff}) - $signed({u_q[32], u_q});
	assign e_abs = e_c[33] ? -e_c : e_c;
	assign tdiff = $signed({2'b00, t_q}) - $signed({u_q[32], u_q});
	assign n_c   = {1'b0, plo_q} - {2'b00, neg_q};
	assign add_c = {1'b0, down_q} + {1'b0, tmp_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_M1: begin
				mul_a = l_q;
				mul_b = a_eff;
			end
			S_M2: begin
				mul_a = au_q;
				mul_b = au_q;
			end
			S_M3: begin
				mul_a = w_eff;
				mul_b = w_eff;
			end
			S_M4: begin
				mul_a = a_eff;
				mul_b = w_eff;
			end
			S_PE2: begin
				mul_a = ae_q;
				mul_b = ae_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cs_a = '0;
		cs_b = '0;
		case (state_q)
			S_DIV0: begin
				cs_a = hi64;
				cs_b = den_q;
			end
			S_DIVI: begin
				cs_a = div_a;
				cs_b = den_q;
			end
			S_SQ: begin
				cs_a = sq_a;
				cs_b = trial;
			end
			default: begin
			end
		endcase
	end

	tmtp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(prod));
	tmtp_csub u_csub (.a(cs_a), .b(cs_b), .ge(cs_ge), .diff(cs_diff));

	assign take = $signed(down_q) > best_down_q;
	assign busy = (state_q != S_IDLE);
	assign emit = (state_q == S_UPD) && last_q && out_free;

	always_comb begin
		if (take) begin
			res.plateau_start  = $signed(plat_q);
			res.rampdown_start = $signed(down_q);
			res.move_end       = $signed(end_q);
		end else begin
			res.plateau_start  = best_plat_q;
			res.rampdown_start = best_down_q;
			res.move_end       = best_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			best_plat_q <= $signed(REARM);
			best_down_q <= $signed(REARM);
			best_end_q  <= $signed(REARM);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_CLS;
				S_CLS: state_q <= S_CLS2;
				S_CLS2: begin
					if (decel_q) begin
						state_q <= S_DIV0;
					end else if (sum_q < (ww_q << 1)) begin
						state_q <= S_SQ;
					end else begin
						state_q <= S_PE;
					end
				end
				S_SQ: begin
					if (cnt_q == 5'd0) begin
						state_q <= S_TRI;
					end
				end
				S_TRI, S_TRI2, S_PE4, S_PE5, S_PE6: state_q <= S_DIV0;
				S_PE: state_q <= S_PE2;
				S_PE2: state_q <= S_PE3;
				S_PE3: state_q <= S_PE4;
				S_ADD: state_q <= S_UPD;
				S_DIV0: state_q <= cs_ge ? S_DIVW : S_DIVI;
				S_DIVI: begin
					if (cnt_q == 5'd0) begin
						state_q <= S_DIVW;
					end
				end
				S_DIVW: state_q <= ret_q;
				S_UPD: begin
					if (!last_q) begin
						if (take) begin
							best_plat_q <= $signed(plat_q);
							best_down_q <= $signed(down_q);
							best_end_q  <= $signed(end_q);
						end
						state_q <= S_IDLE;
					end else if (out_free) begin
						// hand over the kept triple and re-arm
						best_plat_q <= $signed(REARM);
						best_down_q <= $signed(REARM);
						best_end_q  <= $signed(REARM);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				last_q <= item.last_joint;
				l_q    <= item.joint_distance[31] ? 32'(-{item.joint_distance[31],
					item.joint_distance}) : item.joint_distance;
				u_q    <= u_c;
				au_q   <= u_c[32] ? 32'(-u_c) : u_c[31:0];
			end
			S_M2: two_la_q <= prod << 1;
			S_M3: uu_q <= prod;
			S_M4: ww_q <= prod;
			S_CLS: begin
				aw2_q   <= prod << 1;
				decel_q <= (u_q > 33'sd0) && (two_la_q < uu_q);
				sum_q   <= two_la_q + uu_q;
			end
			S_CLS2: begin
				plat_q <= NEG_ONE;
				if (decel_q) begin
					down_q <= '0;
					num_q  <= NUM_W'({l_q, 1'b0}) << FRAC_BITS;
					den_q  <= WIDE_W'(au_q);
					dst_q  <= DST_END;
					ret_q  <= S_UPD;
				end else begin
					num_q <= NUM_W'(sum_q >> 1);
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= 5'd31;
				end
			end
			S_SQ: begin
				// one root bit per step
				rem_q <= cs_ge ? cs_diff : sq_a;
				quo_q <= {quo_q[30:0], cs_ge};
				num_q <= num_q << 2;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					t_q <= {quo_q[30:0], cs_ge};
				end
			end
			S_TRI: begin
				num_q <= tdiff[33] ? '0 : NUM_W'(tdiff[32:0]) << FRAC_BITS;
				den_q <= WIDE_W'(a_eff);
				dst_q <= DST_DOWN;
				ret_q <= S_TRI2;
			end
			S_TRI2: begin
				num_q <= NUM_W'(t_q) << FRAC_BITS;
				den_q <= WIDE_W'(a_eff);
				dst_q <= DST_TMP;
				ret_q <= S_ADD;
			end
			S_PE: begin
				eneg_q <= e_c[33];
				ae_q   <= e_abs[31:0];
			end
			S_PE3: begin
				plo_q <= {1'b0, two_la_q} + (eneg_q ? 65'd0 : {1'b0, prod});
				neg_q <= ww_q + (eneg_q ? prod : '0);
			end
			S_PE4: begin
				// clamp the ramp-down numerator at zero
				num_q <= n_c[65] ? '0 : NUM_W'(n_c[64:0]) << FRAC_BITS;
				den_q <= aw2_q;
				dst_q <= DST_DOWN;
				ret_q <= S_PE5;
			end
			S_PE5: begin
				num_q <= NUM_W'(ae_q) << FRAC_BITS;
				den_q <= WIDE_W'(a_eff);
				dst_q <= DST_PLAT;
				ret_q <= S_PE6;
			end
			S_PE6: begin
				num_q <= NUM_W'(w_eff) << FRAC_BITS;
				den_q <= WIDE_W'(a_eff);
				dst_q <= DST_TMP;
				ret_q <= S_ADD;
			end
			S_ADD: end_q <= add_c[31] ? SAT : add_c[31:0];
			S_DIV0: begin
				// quotient of 2^31 or more saturates at once
				if (cs_ge) begin
					quo_q <= SAT;
				end else begin
					rem_q <= hi64;
					quo_q <= '0;
					cnt_q <= 5'd30;
				end
			end
			S_DIVI: begin
				rem_q <= cs_ge ? cs_diff : div_a;
				quo_q <= {quo_q[30:0], cs_ge};
				cnt_q <= cnt_q - 5'd1;
			end
			S_DIVW: begin
				case (dst_q)
					DST_DOWN: down_q <= quo_q;
					DST_PLAT: plat_q <= quo_q;
					DST_TMP:  tmp_q  <= quo_q;
					DST_END:  end_q  <= quo_q;
					default:  tmp_q  <= quo_q;
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: sv/trapezoid_move_time_predictor.sv
// Top level of the trapezoid move-time predictor: ports, limits, result register.
//
// Feed one joint per item on in_data (distance, velocity, last mark) with
// in_valid; the item is taken when in_stall is low. in_stall stays high while
// a joint is being worked on. Each joint is classed as decelerate-only,
// triangle or plateau profile and timed; the joint with the latest ramp-down
// start is kept. On a joint marked last the kept plateau start, ramp-down
// start and end time come out on out_data and the keeper re-arms to -10.
// A decelerate-only joint needs one division, a triangle a square root and two
// divisions, a plateau three divisions (a saturating quotient skips its 31 steps):
// the root and each division step on one shared 64-bit compare-subtract unit.
// out_valid rises and in_stall drops at the edge that ends the joint.
// out_valid holds with stable data while out_stall is high; the next joint
// is still taken, and only its own result waits for the register to free up.
// Limits are written over cfg_valid/cfg_index/cfg_data (cfg_ready is always high);
// the user must write them only while no joint is in flight (block does not enforce).
// Reset sets both limits to 0.5, clears out_valid and re-arms the keeper.
module trapezoid_move_time_predictor import tmtp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tmtp_in_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tmtp_out_t          out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [LIMIT_W-1:0] cfg_data
);

	localparam logic [LIMIT_W-1:0] HALF = LIMIT_W'(2 ** (FRAC_BITS - 1));

	logic [LIMIT_W-1:0] accel_q, vel_q;
	logic out_valid_q;
	tmtp_out_t out_data_q;
	logic busy, emit, out_free;
	tmtp_out_t res;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// hold the limits; the user must write them only between joints, not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= HALF;
			vel_q   <= HALF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACCEL: accel_q <= cfg_data;
				REG_VEL:   vel_q   <= cfg_data;
				default:   accel_q <= cfg_data;
			endcase
		end
	end

	tmtp_core #(.FRAC_BITS(FRAC_BITS)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && !in_stall),
		.item     (in_data),
		.accel    (accel_q),
		.vel      (vel_q),
		.out_free (out_free),
		.busy     (busy),
		.emit     (emit),
		.res      (res)
	);

	// result register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= res;
		end
	end

endmodule

FILE: sim/trapezoid_move_time_predictor_tb.sv
// Self-checking testbench for the trapezoid move-time predictor.
`timescale 1ns / 1ps

module trapezoid_move_time_predictor_tb;
	import tmtp_pkg::*;

	localparam int FRAC = 16;
	localparam int RAND_ITEMS = 1550;
	localparam int CYCLE_LIMIT = 2000000;
	// give in-flight joint work room to finish
	localparam int DRAIN_CYCLES = 300;
	localparam logic signed [31:0] REARM = -32'sd655360;   // -10.0
	localparam logic signed [31:0] NO_PLATEAU = -32'sd65536; // -1.0
	localparam logic signed [127:0] SAT = 128'sd2147483647;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	tmtp_in_t in_data;
	logic out_valid;
	logic out_stall;
	tmtp_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [LIMIT_W-1:0] cfg_data;

	int send_idle_pct;
	int recv_idle_pct;
	int cycles = 0;

	trapezoid_move_time_predictor #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Profile timing predictor plus the queue of move times still owed by the block.
	class move_time_board;
		logic [LIMIT_W-1:0] accel;
		logic [LIMIT_W-1:0] vel;
		logic signed [31:0] keep_plateau;
		logic signed [31:0] keep_rampdown;
		logic signed [31:0] keep_end;
		tmtp_out_t owed_times[$];
		int errors;

		function new();
			accel = 31'd32768;
			vel = 31'd32768;
			keep_plateau = REARM;
			keep_rampdown = REARM;
			keep_end = REARM;
			errors = 0;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
			errors++;
		endtask

		function void set_limit(logic idx, logic [LIMIT_W-1:0] val);
			if (idx == REG_ACCEL)
				accel = val;
			else
				vel = val;
		endfunction

		// floor of a nonnegative quotient, clipped to the largest positive word
		function logic signed [31:0] quot_clip(logic signed [127:0] n, logic signed [127:0] d);
			logic signed [127:0] q;
			q = n / d;
			return (q > SAT) ? SAT[31:0] : q[31:0];
		endfunction

		function logic signed [31:0] sum_clip(logic signed [31:0] a, logic signed [31:0] b);
			logic signed [32:0] s;
			s = 33'(a) + 33'(b);
			return (s > 33'sd2147483647) ? 32'sh7fffffff : s[31:0];
		endfunction

		function logic [63:0] root_floor(logic [63:0] x);
			logic [63:0] r;
			logic [63:0] b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x)
				b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function void note_joint(tmtp_in_t j);
			longint jdist;
			longint v;
			logic signed [127:0] a, w, lmag, u, uu, two_la, t, diff, e, ae, num;
			logic signed [31:0] c_plat, c_down, c_end;
			tmtp_out_t res;
			jdist = longint'(j.joint_distance);
			v = longint'(j.joint_velocity);
			a = (accel == 0) ? 128'sd1 : {97'd0, accel};
			w = (vel == 0) ? 128'sd1 : {97'd0, vel};
			lmag = 128'((jdist < 0) ? -jdist : jdist);
			u = 128'((jdist < 0) ? -v : v);
			uu = u * u;
			two_la = 2 * lmag * a;
			if (u > 0 && two_la < uu) begin
				// decelerate only
				c_plat = NO_PLATEAU;
				c_down = 0;
				c_end = quot_clip((2 * lmag) <<< FRAC, u);
			end else if (two_la + uu < 2 * w * w) begin
				// triangle: peak velocity never reaches the cruise limit
				t = {64'd0, root_floor(64'((two_la + uu) >>> 1))};
				diff = t - u;
				if (diff < 0)
					diff = 0;
				c_plat = NO_PLATEAU;
				c_down = quot_clip(diff <<< FRAC, a);
				c_end = sum_clip(c_down, quot_clip(t <<< FRAC, a));
			end else begin
				e = w - u;
				ae = (e < 0) ? -e : e;
				num = two_la - w * w + ((e < 0) ? -(ae * ae) : ae * ae);
				if (num < 0)
					num = 0;
				c_plat = quot_clip(ae <<< FRAC, a);
				c_down = quot_clip(num <<< FRAC, 2 * a * w);
				c_end = sum_clip(c_down, quot_clip(w <<< FRAC, a));
			end
			if (c_down > keep_rampdown) begin
				keep_rampdown = c_down;
				keep_plateau = c_plat;
				keep_end = c_end;
			end
			if (j.last_joint) begin
				res.plateau_start = keep_plateau;
				res.rampdown_start = keep_rampdown;
				res.move_end = keep_end;
				owed_times.push_back(res);
				keep_plateau = REARM;
				keep_rampdown = REARM;
				keep_end = REARM;
			end
		endfunction

		task check_times(tmtp_out_t got);
			tmtp_out_t want;
			if (owed_times.size() == 0) begin
				report("unexpected result", got.rampdown_start, 32'h0);
			end else begin
				want = owed_times.pop_front();
				if (got.plateau_start !== want.plateau_start)
					report("plateau_start", got.plateau_start, want.plateau_start);
				if (got.rampdown_start !== want.rampdown_start)
					report("rampdown_start", got.rampdown_start, want.rampdown_start);
				if (got.move_end !== want.move_end)
					report("move_end", got.move_end, want.move_end);
			end
		endtask
	endclass

	move_time_board board = new();

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watch all three channels at the edge; values seen here are pre-edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_joint(in_data);
			if (cfg_valid && cfg_ready)
				board.set_limit(cfg_index, cfg_data);
			if (out_valid && !out_stall)
				board.check_times(out_data);
		end
	end

	// Receiver backpressure at the current idle rate.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("trapezoid_move_time_predictor_tb: FAIL");
			$finish;
		end
	end

	// Hand one joint to the block; valid stays high afterwards until the next call.
	task send_joint(logic signed [31:0] jd, logic signed [31:0] v, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{joint_distance: jd, joint_velocity: v, last_joint: last};
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Drop valid and let every owed result and any trailing joint work drain.
	task drain();
		in_valid <= 1'b0;
		while (board.owed_times.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Raise valid with one register write and wait for it to be taken; the caller drops valid.
	task write_limit(logic idx, logic [LIMIT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// Word with a random magnitude scale so small moves and full-range ones both occur.
	function logic [31:0] spread_word();
		int k;
		logic [32:0] mask;
		logic [31:0] w;
		k = $urandom_range(32);
		mask = (33'd1 << k) - 1;
		w = $urandom & mask[31:0];
		if ($urandom_range(1))
			w = -w;
		return w;
	endfunction

	task random_moves(int count, bit pause_midway);
		int sent;
		int group;
		int i;
		sent = 0;
		while (sent < count) begin
			group = $urandom_range(6, 1);
			for (i = 0; i < group; i++) begin
				// mostly clean moves; now and then leave the move open
				send_joint(spread_word(), spread_word(),
					(i == group - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
				sent++;
			end
			// hold off until every owed result is out
			if (pause_midway && sent >= count / 2) begin
				pause_midway = 0;
				in_valid <= 1'b0;
				while (board.owed_times.size() != 0)
					@(posedge clk);
			end
		end
	endtask

	task set_limits(logic [LIMIT_W-1:0] acc, logic [LIMIT_W-1:0] v);
		drain();
		write_limit(REG_ACCEL, acc);
		write_limit(REG_VEL, v);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ACCEL;
		cfg_data = '0;
		send_idle_pct = 31;
		recv_idle_pct = 84;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed joints at the default limits.
		send_joint(32'sd0, 32'sd0, 1'b1);                       // zero distance, at rest
		send_joint(32'sd0, -32'sd65536, 1'b1);                  // zero distance counts as positive
		send_joint(32'sd100, 32'sd65536, 1'b1);                 // decelerate only
		send_joint(-32'sd100, -32'sd65536, 1'b1);               // decelerate, negative move
		send_joint(32'sd1000, 32'sd0, 1'b1);                    // triangle
		send_joint(32'sd1000, 32'sd20000, 1'b1);                // decelerate only, from a head start
		send_joint(32'sd196608, 32'sd0, 1'b1);                  // plateau
		send_joint(32'sd196608, 32'sd131072, 1'b1);             // decelerate only, entering above cruise
		send_joint(-32'sd196608, 32'sd131072, 1'b1);            // plateau, moving the wrong way
		send_joint(32'sh7fffffff, 32'sh7fffffff, 1'b1);
		send_joint(32'sh80000000, 32'sh80000000, 1'b1);         // largest |u|
		send_joint(32'sh7fffffff, 32'sh80000000, 1'b1);
		send_joint(32'sh80000000, 32'sh7fffffff, 1'b1);
		send_joint(32'sd1, 32'sh7fffffff, 1'b1);                // decel end rounds to zero
		// multi-joint move: first kept, then a strictly later one, then a tie
		send_joint(32'sd1000, 32'sd0, 1'b0);
		send_joint(32'sd196608, 32'sd0, 1'b0);
		send_joint(32'sd196608, 32'sd0, 1'b0);
		send_joint(32'sd100, 32'sd65536, 1'b1);
		// a move made only of decelerating joints beats the re-arm value
		send_joint(32'sd100, 32'sd65536, 1'b0);
		send_joint(32'sd50, 32'sd65536, 1'b1);

		// Extremes of the limits, zero acting as one.
		set_limits(31'd1, 31'h7fffffff);
		send_joint(32'sd196608, 32'sd0, 1'b1);
		send_joint(32'sh80000000, 32'sd5, 1'b1);
		set_limits(31'h7fffffff, 31'd1);
		send_joint(32'sd196608, 32'sd0, 1'b1);
		send_joint(32'sh7fffffff, -32'sd3, 1'b1);
		set_limits(31'd0, 31'd0);
		send_joint(32'sd1000, 32'sd10, 1'b1);
		send_joint(-32'sd1000, 32'sd0, 1'b1);

		// Random part, sender and receiver idling in three regimes.
		set_limits(31'd32768, 31'd32768);
		random_moves(350, 1'b1);
		set_limits(31'd1, 31'd1);
		random_moves(150, 1'b0);
		send_idle_pct = 84;
		recv_idle_pct = 31;
		set_limits(31'h7fffffff, 31'h7fffffff);
		random_moves(150, 1'b0);
		set_limits(LIMIT_W'($urandom_range(31'h7fffffff, 1)),
			LIMIT_W'($urandom_range(31'h7fffffff, 1)));
		random_moves(300, 1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limits(LIMIT_W'($urandom_range(1 << 20, 1)), LIMIT_W'($urandom_range(1 << 20, 1)));
		random_moves(300, 1'b0);
		set_limits(31'd65536, 31'd131072);
		random_moves(300, 1'b0);

		drain();
		if (board.errors == 0 && board.owed_times.size() == 0) begin
			$display("trapezoid_move_time_predictor_tb: PASS");
		end else begin
			if (board.owed_times.size() != 0)
				$display("%0d results never arrived", board.owed_times.size());
			$display("trapezoid_move_time_predictor_tb: FAIL");
		end
		$finish;
	end

endmodule
